/* rtl/gsfs_pkg.sv */
// Shared types, constants and the exponent table of the Gaussian field sampler.
package gsfs_pkg;

   // Default number of table entries.
   localparam int MAX_GAUSS = 16;
   // Largest grid_log2 that is honored; larger values clamp to it.
   localparam logic [3:0] MAX_GRID_LOG2 = 4'd10;

   // Configuration register indexes.
   localparam logic CSR_GRID_LOG2    = 1'b0;
   localparam logic CSR_ACTIVE_COUNT = 1'b1;
   localparam int   CSR_DATA_W       = 5;

   // Reset values of the configuration registers.
   localparam logic [3:0] GRID_LOG2_RESET    = 4'd8;
   localparam logic [4:0] ACTIVE_COUNT_RESET = 5'd0;

   // Arithmetic widths and constants.
   localparam int COORD_W  = 25;   // grid coordinate, signed Q.14
   localparam int DIFF_W   = 26;   // coordinate minus center, signed
   localparam int MAG_W    = 24;   // magnitude fed to the multiplier
   localparam int PROD_W   = 48;   // multiplier result
   localparam int NUM_W    = 60;   // dividend: square shifted by the Q.12 scale
   localparam int DEN_W    = 32;   // divisor: sigma squared
   localparam int QUO_W    = 17;   // clipped ratio, up to 16.0 in Q.12
   localparam int DIV_STEPS = 17;
   localparam logic [QUO_W-1:0] QUO_CLIP = 17'd65536;
   localparam logic [MAG_W-1:0] LOG2E_Q12 = 24'd5909;
   localparam logic signed [COORD_W-1:0] COORD_HALF = 25'sd8192;
   localparam int VAL_W = 20;

   // One input transaction.
   typedef struct packed {
      logic              opcode;
      logic [3:0]        slot;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] amplitude;
      logic [15:0]       sigma_x;
      logic [15:0]       sigma_y;
      logic [9:0]        row;
      logic [9:0]        col;
   } gsfs_req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [9:0]              out_row;
      logic [9:0]              out_col;
      logic                    saturated;
   } gsfs_rsp_type;

   // One stored Gaussian.
   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] amplitude;
      logic [15:0]        sigma_x;
      logic [15:0]        sigma_y;
   } gsfs_entry_type;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_EVAL = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQX,
      ST_SSX,
      ST_DIVX,
      ST_WAITX,
      ST_SQY,
      ST_SSY,
      ST_DIVY,
      ST_WAITY,
      ST_EXPM,
      ST_EXPT,
      ST_AMUL,
      ST_ACC,
      ST_FIN
   } gsfs_state_type;

   // 2^(-k/16) in Q0.16, with 1.0 held as the largest code.
   function automatic logic [15:0] pow2_frac(input logic [3:0] k);
      logic [15:0] r;
      case (k)
         4'd0:    r = 16'd65535;
         4'd1:    r = 16'd62757;
         4'd2:    r = 16'd60097;
         4'd3:    r = 16'd57549;
         4'd4:    r = 16'd55109;
         4'd5:    r = 16'd52773;
         4'd6:    r = 16'd50535;
         4'd7:    r = 16'd48393;
         4'd8:    r = 16'd46341;
         4'd9:    r = 16'd44376;
         4'd10:   r = 16'd42495;
         4'd11:   r = 16'd40693;
         4'd12:   r = 16'd38968;
         4'd13:   r = 16'd37316;
         4'd14:   r = 16'd35734;
         default: r = 16'd34219;
      endcase
      return r;
   endfunction

endpackage

/* rtl/gaussian_sum_field_sampler.sv */
// Top level of the Gaussian field sampler: table, shared multiplier and sequencer.
// A load transaction leaves busy low, so loads can follow every cycle while no evaluation runs.
// An evaluate transaction raises busy until its result strobe rises; the next start can be
// taken at the edge at which that result is sampled. Each Gaussian uses the shared multiplier
// and two divider passes of up to 17 steps; a zero sigma skips the divider. Results cannot be stalled.
// Synchronous reset clears sequencer, strobe, configuration registers and divider control.
module gaussian_sum_field_sampler #(
   parameter int MaxGauss = gsfs_pkg::MAX_GAUSS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  gsfs_pkg::gsfs_req_type               req_data,
   output logic                                 rsp_valid,
   output gsfs_pkg::gsfs_rsp_type               rsp_data,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [gsfs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gsfs_pkg::*;

   localparam int AW  = (MaxGauss > 1) ? $clog2(MaxGauss) : 1;
   localparam int CW  = $clog2(MaxGauss + 1);
   localparam int NW  = (CW > 5) ? CW : 5;
   localparam int SW0 = 17 + CW;
   localparam int SW  = (SW0 > VAL_W + 1) ? SW0 : VAL_W + 1;
   localparam logic signed [SW-1:0] SUM_MAX = SW'((1 <<< (VAL_W - 1)) - 1);
   localparam logic signed [SW-1:0] SUM_MIN = -SW'(1 <<< (VAL_W - 1));

   gsfs_state_type state_ff, state_in;

   logic [3:0]  grid_ff;
   logic [4:0]  active_ff;

   gsfs_entry_type mem [MaxGauss];
   gsfs_entry_type rd_ff;

   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [9:0]        row_ff, col_ff;
   logic [NW-1:0]     n_ff, k_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] sq_ff;
   logic [QUO_W-1:0]  qx_ff;
   logic [QUO_W:0]    t_ff;
   logic [15:0]       e_ff;
   logic signed [SW-1:0] sum_ff;
   logic              rsp_valid_ff;
   gsfs_rsp_type      rsp_ff;

   logic              accept;
   logic              load_we;
   logic [3:0]        g_eff;
   logic [3:0]        shamt;
   logic signed [COORD_W-1:0] x_in, y_in;
   logic [NW-1:0]     n_in;
   logic signed [DIFF_W-1:0] dx, dy, dx_neg, dy_neg;
   logic [MAG_W-1:0]  ax, ay;
   logic [16:0]       amp_ext;
   logic [15:0]       amp_mag;
   logic [MAG_W-1:0]  mul_a, mul_b;
   logic              div_start;
   logic [NUM_W-1:0]  div_num;
   logic              div_done;
   logic [QUO_W-1:0]  div_quo;
   logic [15:0]       term;
   logic signed [SW-1:0] term_s;
   logic              last;

   assign accept  = start && !busy;
   assign load_we = accept && (req_data.opcode == OP_LOAD)
                    && (32'(req_data.slot) < 32'(MaxGauss));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff   <= GRID_LOG2_RESET;
         active_ff <= ACTIVE_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_LOG2:    grid_ff   <= csr_wdata[3:0];
            CSR_ACTIVE_COUNT: active_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Gaussian table with a registered read at the current entry.
   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[AW'(req_data.slot)] <= '{center_x:  req_data.center_x,
                                      center_y:  req_data.center_y,
                                      amplitude: req_data.amplitude,
                                      sigma_x:   req_data.sigma_x,
                                      sigma_y:   req_data.sigma_y};
      end
      rd_ff <= mem[k_ff[AW-1:0]];
   end

   // Grid point to Q.14 coordinates, with grid size and count clamped.
   always_comb begin
      g_eff = grid_ff;
      if (g_eff < 4'd1) g_eff = 4'd1;
      if (g_eff > MAX_GRID_LOG2) g_eff = MAX_GRID_LOG2;
      shamt = 4'd14 - g_eff;
      x_in  = $signed({2'b00, 23'(req_data.row) << shamt}) - COORD_HALF;
      y_in  = $signed({2'b00, 23'(req_data.col) << shamt}) - COORD_HALF;
      n_in  = (NW'(active_ff) > NW'(MaxGauss)) ? NW'(MaxGauss) : NW'(active_ff);
   end

   // Distances from the center, amplitude magnitude, signed term, last-entry flag and dividend.
   always_comb begin
      dx      = $signed({x_ff[COORD_W-1], x_ff}) - DIFF_W'(rd_ff.center_x);
      dy      = $signed({y_ff[COORD_W-1], y_ff}) - DIFF_W'(rd_ff.center_y);
      dx_neg  = -dx;
      dy_neg  = -dy;
      ax      = dx[DIFF_W-1] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
      ay      = dy[DIFF_W-1] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];
      amp_ext = -{rd_ff.amplitude[15], rd_ff.amplitude};
      amp_mag = rd_ff.amplitude[15] ? amp_ext[15:0] : rd_ff.amplitude;
      term    = prod_ff[31:16];
      term_s  = rd_ff.amplitude[15] ? -SW'({1'b0, term}) : SW'({1'b0, term});
      last    = (k_ff + NW'(1)) >= n_ff;
      div_num = {sq_ff, 12'd0};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && req_data.opcode == OP_EVAL) begin
            state_in = (n_in == '0) ? ST_FIN : ST_FETCH;
         end
         ST_FETCH: state_in = ST_SQX;
         ST_SQX:   state_in = (rd_ff.sigma_x == '0 || rd_ff.sigma_y == '0) ? ST_AMUL : ST_SSX;
         ST_SSX:   state_in = ST_DIVX;
         ST_DIVX:  state_in = ST_WAITX;
         ST_WAITX: if (div_done) state_in = ST_SQY;
         ST_SQY:   state_in = ST_SSY;
         ST_SSY:   state_in = ST_DIVY;
         ST_DIVY:  state_in = ST_WAITY;
         ST_WAITY: if (div_done) state_in = ST_EXPM;
         ST_EXPM:  state_in = (t_ff[QUO_W:16] != '0) ? ST_AMUL : ST_EXPT;
         ST_EXPT:  state_in = ST_AMUL;
         ST_AMUL:  state_in = ST_ACC;
         ST_ACC:   state_in = last ? ST_FIN : ST_FETCH;
         ST_FIN:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Multiplier operands and divider start by state.
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_SQX:  begin mul_a = ax; mul_b = ax; end
         ST_SSX:  begin mul_a = MAG_W'(rd_ff.sigma_x); mul_b = MAG_W'(rd_ff.sigma_x); end
         ST_SQY:  begin mul_a = ay; mul_b = ay; end
         ST_SSY:  begin mul_a = MAG_W'(rd_ff.sigma_y); mul_b = MAG_W'(rd_ff.sigma_y); end
         ST_EXPM: begin mul_a = MAG_W'(t_ff[15:0]); mul_b = LOG2E_Q12; end
         ST_AMUL: begin mul_a = MAG_W'(amp_mag); mul_b = MAG_W'(e_ff); end
         ST_DIVX, ST_DIVY: div_start = 1'b1;
         default: ;
      endcase
   end

   // Shared multiplier, registered.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Shared divider for both axes.
   gsfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (prod_ff[DEN_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sequencer state and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FIN);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (accept && req_data.opcode == OP_EVAL) begin
            x_ff   <= x_in;
            y_ff   <= y_in;
            row_ff <= req_data.row;
            col_ff <= req_data.col;
            n_ff   <= n_in;
            k_ff   <= '0;
            sum_ff <= '0;
         end
         ST_SQX:   if (rd_ff.sigma_x == '0 || rd_ff.sigma_y == '0) e_ff <= '0;
         ST_SSX:   sq_ff <= prod_ff;
         ST_WAITX: if (div_done) qx_ff <= div_quo;
         ST_SSY:   sq_ff <= prod_ff;
         ST_WAITY: if (div_done) t_ff <= {1'b0, qx_ff} + {1'b0, div_quo};
         ST_EXPM:  if (t_ff[QUO_W:16] != '0) e_ff <= '0;
         ST_EXPT:  e_ff <= pow2_frac(prod_ff[23:20]) >> prod_ff[28:24];
         ST_ACC: begin
            sum_ff <= sum_ff + term_s;
            k_ff   <= k_ff + NW'(1);
         end
         ST_FIN: begin
            rsp_ff.out_row <= row_ff;
            rsp_ff.out_col <= col_ff;
            if (sum_ff > SUM_MAX) begin
               rsp_ff.value     <= SUM_MAX[VAL_W-1:0];
               rsp_ff.saturated <= 1'b1;
            end else if (sum_ff < SUM_MIN) begin
               rsp_ff.value     <= SUM_MIN[VAL_W-1:0];
               rsp_ff.saturated <= 1'b1;
            end else begin
               rsp_ff.value     <= sum_ff[VAL_W-1:0];
               rsp_ff.saturated <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result strobe lasts one cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   // A result is only shown once the sequencer is back at rest.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> state_ff == ST_IDLE)
      else $error("result while sequencer busy");
   // A clipped result sits at one end of the range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
      (rsp_data.value == SUM_MAX[VAL_W-1:0] || rsp_data.value == SUM_MIN[VAL_W-1:0]))
      else $error("saturation flag without clipped value");
   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAITX || state_ff == ST_WAITY))
      else $error("divider finished outside a wait state");

endmodule

/* rtl/gsfs_div.sv */
// Restoring divider, one quotient bit per cycle, with the quotient clipped to 16.0.
module gsfs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gsfs_pkg::NUM_W-1:0] num,
   input  logic [gsfs_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic [gsfs_pkg::QUO_W-1:0] quotient
);
   import gsfs_pkg::*;

   localparam int HI_W = NUM_W - QUO_W;

   logic              run_ff;
   logic [4:0]        cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  low_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              done_ff;
   logic [QUO_W-1:0]  quo_ff;

   logic [DEN_W:0]    rem2;
   logic [DEN_W:0]    diff;
   logic              ge;
   logic [QUO_W-1:0]  q_next;
   logic              over;

   // Quotient would need more than its bits: clip straight away.
   assign over = num[NUM_W-1:QUO_W] >= HI_W'(den);

   // One restoring step.
   always_comb begin
      rem2   = {rem_ff, low_ff[QUO_W-1]};
      diff   = rem2 - {1'b0, den_ff};
      ge     = rem2 >= {1'b0, den_ff};
      q_next = {low_ff[QUO_W-2:0], ge};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= !over;
            done_ff <= over;
            cnt_ff  <= 5'(DIV_STEPS);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[QUO_W+DEN_W-1:QUO_W];
         low_ff <= num[QUO_W-1:0];
         den_ff <= den;
         quo_ff <= QUO_CLIP;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
         low_ff <= q_next;
         if (cnt_ff == 5'd1) begin
            quo_ff <= (q_next > QUO_CLIP) ? QUO_CLIP : q_next;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // A finish pulse never comes while the divider still iterates.
   assert property (@(posedge clock) disable iff (reset) done |-> !run_ff)
      else $error("divider finished while running");
   // The clipped quotient never exceeds 16.0.
   assert property (@(posedge clock) disable iff (reset) done |-> quotient <= QUO_CLIP)
      else $error("divider quotient above clip");
   // A run begins with its full step count loaded.
   assert property (@(posedge clock) disable iff (reset)
      (start && !over) |=> run_ff && cnt_ff == 5'(DIV_STEPS))
      else $error("divider run did not begin");

endmodule

/* dv/tb_gaussian_sum_field_sampler.sv */
// Self-checking testbench for the Gaussian field sampler: directed and random loads and grid evaluations.
module tb_gaussian_sum_field_sampler;
   timeunit 1ns;
   timeprecision 1ps;
   import gsfs_pkg::*;

   // Expected field values, kept in arrival order of the evaluate transactions.
   class field_scoreboard;
      gsfs_rsp_type pending_q[$];
      int errors = 0;

      function void note_request(gsfs_rsp_type exp_rsp);
         pending_q.push_back(exp_rsp);
      endfunction

      function void check_result(gsfs_rsp_type got);
         gsfs_rsp_type want;
         if (pending_q.size() == 0) begin
            $error("unexpected result value=%0d row=%0d col=%0d",
                   got.value, got.out_row, got.out_col);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.value !== want.value) begin
            $error("value expected %0d actual %0d", want.value, got.value);
            errors++;
         end
         if (got.out_row !== want.out_row) begin
            $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
            errors++;
         end
         if (got.out_col !== want.out_col) begin
            $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

   localparam int LIMIT_CYCLES = 4000000;
   localparam int DRAIN_CYCLES = 900;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   gsfs_req_type req_data = '0;
   logic rsp_valid;
   gsfs_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_GRID_LOG2;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gaussian_sum_field_sampler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the Gaussian table and registers.
   gsfs_entry_type gauss_table[MAX_GAUSS];
   logic [3:0] grid_log2_shadow;
   logic [4:0] active_count_shadow;
   field_scoreboard field_sb;
   int unsigned cycle_count = 0;
   bit idle_allowed = 1'b1;

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("gaussian_sum_field_sampler regression: fail");
         $finish;
      end
   end

   // Results are sampled at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) field_sb.check_result(rsp_data);
   end

   // Squared ratio in Q.12, clipped to 16.0.
   function automatic longint unsigned ratio_q12(longint d, logic [15:0] s);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q = ((mag * mag) << 12) / (longint'(s) * longint'(s));
      return (q > 65536) ? 65536 : q;
   endfunction

   // exp(-t) in unsigned Q0.16 through the base-2 table and a shift.
   function automatic longint decay_q16(longint unsigned t);
      logic [15:0] frac_tab[16] = '{16'd65535, 16'd62757, 16'd60097, 16'd57549,
         16'd55109, 16'd52773, 16'd50535, 16'd48393, 16'd46341, 16'd44376,
         16'd42495, 16'd40693, 16'd38968, 16'd37316, 16'd35734, 16'd34219};
      longint unsigned u;
      if (t >= 65536) return 0;
      u = (t * 5909) >> 12;
      return longint'(frac_tab[(u >> 8) & 15]) >> (u >> 12);
   endfunction

   // Predicted field value at one grid point.
   function automatic gsfs_rsp_type field_at(logic [9:0] row, logic [9:0] col);
      gsfs_rsp_type r;
      int g, n;
      longint x, y, acc, e, prod;
      g = grid_log2_shadow;
      if (g < 1) g = 1;
      if (g > MAX_GRID_LOG2) g = MAX_GRID_LOG2;
      n = (active_count_shadow > MAX_GAUSS) ? MAX_GAUSS : active_count_shadow;
      x = -8192 + (longint'(row) << (14 - g));
      y = -8192 + (longint'(col) << (14 - g));
      acc = 0;
      for (int k = 0; k < n; k++) begin
         if (gauss_table[k].sigma_x == 0 || gauss_table[k].sigma_y == 0) continue;
         e = decay_q16(ratio_q12(x - longint'(gauss_table[k].center_x), gauss_table[k].sigma_x)
                     + ratio_q12(y - longint'(gauss_table[k].center_y), gauss_table[k].sigma_y));
         prod = longint'(gauss_table[k].amplitude) * e;
         acc += prod / 65536;
      end
      r.saturated = 1'b0;
      if (acc > 524287) begin acc = 524287; r.saturated = 1'b1; end
      if (acc < -524288) begin acc = -524288; r.saturated = 1'b1; end
      r.value = acc[19:0];
      r.out_row = row;
      r.out_col = col;
      return r;
   endfunction

   // Random gap before a transaction, unless idling is switched off; start drops meanwhile.
   task automatic maybe_idle();
      while (idle_allowed && $urandom_range(99) < 13) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Issue one transaction and update the shadow state when it is accepted.
   // Start stays up after the accepting edge until the next caller drives it again.
   task automatic send_request(gsfs_req_type req);
      maybe_idle();
      start <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (req.opcode == OP_LOAD) begin
         gauss_table[req.slot] = '{req.center_x, req.center_y, req.amplitude,
                                   req.sigma_x, req.sigma_y};
      end else begin
         field_sb.note_request(field_at(req.row, req.col));
      end
      @(negedge clock);
   endtask

   task automatic load_slot(logic [3:0] slot, logic [15:0] cx, logic [15:0] cy,
                            logic [15:0] amp, logic [15:0] sx, logic [15:0] sy);
      gsfs_req_type req;
      req = '{OP_LOAD, slot, cx, cy, amp, sx, sy, 10'($urandom), 10'($urandom)};
      send_request(req);
   endtask

   task automatic eval_point(logic [9:0] row, logic [9:0] col);
      gsfs_req_type req;
      req = '{OP_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), row, col};
      send_request(req);
   endtask

   // Register write only once all results are in and the sequencer has settled.
   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] val);
      start <= 1'b0;
      while (field_sb.pending_q.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GRID_LOG2) grid_log2_shadow = val[3:0];
      else active_count_shadow = val;
      @(negedge clock);
   endtask

   // Random sigma: mostly moderate, sometimes zero or extreme.
   function automatic logic [15:0] pick_sigma();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 64));
         default: return 16'($urandom_range(512, 12000));
      endcase
   endfunction

   // Load every slot so that any active_count reads only written entries.
   task automatic fill_table();
      for (int k = 0; k < MAX_GAUSS; k++)
         load_slot(k[3:0], 16'($signed($urandom_range(0, 16384)) - 8192),
                   16'($signed($urandom_range(0, 16384)) - 8192),
                   16'($urandom), pick_sigma(), pick_sigma());
   endtask

   initial begin
      int grid_pick;
      int active_pick;
      field_sb = new();
      grid_log2_shadow = GRID_LOG2_RESET;
      active_count_shadow = ACTIVE_COUNT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty sum at reset settings, then field extremes.
      eval_point(10'd0, 10'd0);
      eval_point(10'd1023, 10'd1023);
      load_slot(4'd0, 16'h0000, 16'h0000, 16'h7FFF, 16'h1000, 16'h1000);
      load_slot(4'd1, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
      load_slot(4'd2, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h1000);
      load_slot(4'd3, 16'h0100, 16'hFF00, 16'h1234, 16'h0001, 16'h0001);
      for (int k = 4; k < MAX_GAUSS; k++)
         load_slot(k[3:0], 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      write_csr(CSR_ACTIVE_COUNT, 5'd1);
      eval_point(10'd128, 10'd128);
      write_csr(CSR_ACTIVE_COUNT, 5'd31);
      eval_point(10'd128, 10'd128);
      eval_point(10'd1023, 10'd0);
      write_csr(CSR_GRID_LOG2, 5'd0);
      eval_point(10'd1, 10'd1);
      write_csr(CSR_GRID_LOG2, 5'd15);
      eval_point(10'd512, 10'd1023);
      write_csr(CSR_GRID_LOG2, 5'd10);
      eval_point(10'd1023, 10'd1023);
      write_csr(CSR_ACTIVE_COUNT, 5'd4);
      eval_point(10'd0, 10'd0);
      write_csr(CSR_ACTIVE_COUNT, 5'd0);
      eval_point(10'd300, 10'd700);

      // Random phases; the middle one runs with no idling at all.
      for (int phase = 0; phase < 12; phase++) begin
         idle_allowed = (phase != 5);
         fill_table();
         grid_pick = (phase == 0) ? 1 : (phase == 1) ? 10 : $urandom_range(0, 15);
         active_pick = (phase == 2) ? 16 : $urandom_range(0, 6);
         write_csr(CSR_GRID_LOG2, grid_pick[CSR_DATA_W-1:0]);
         write_csr(CSR_ACTIVE_COUNT, active_pick[CSR_DATA_W-1:0]);
         for (int i = 0; i < 60; i++) begin
            if ($urandom_range(4) == 0)
               load_slot(4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         pick_sigma(), pick_sigma());
            else if ($urandom_range(3) == 0)
               eval_point(10'($urandom), 10'($urandom));
            else
               eval_point(10'($urandom_range(0, (1 << MAX_GRID_LOG2) - 1) >>
                               (MAX_GRID_LOG2 - ((grid_pick < 1) ? 1 :
                                (grid_pick > 10) ? 10 : grid_pick))),
                          10'($urandom_range(0, 1023) >>
                               (MAX_GRID_LOG2 - ((grid_pick < 1) ? 1 :
                                (grid_pick > 10) ? 10 : grid_pick))));
         end
      end

      // Drain outstanding results, then let the pipeline settle.
      start <= 1'b0;
      while (field_sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (field_sb.errors == 0 && field_sb.pending_q.size() == 0) begin
         $display("gaussian_sum_field_sampler regression: pass");
      end else begin
         $display("gaussian_sum_field_sampler regression: fail");
      end
      $finish;
   end
endmodule
